/* hdl/multi_sensor_presence_qualifier_defines.svh */
// Assertion macros used by the presence qualifier checker.
// No dependencies; include with the bare file name.
`ifndef MULTI_SENSOR_PRESENCE_QUALIFIER_DEFINES_SVH
`define MULTI_SENSOR_PRESENCE_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define MSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/msp_pkg.sv */
// Package for the multi-sensor presence qualifier: widths, register indexes,
// reset values and the shared config/result types. No dependencies.
package msp_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int COUNT_WIDTH  = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  typedef logic [NUM_CHANNELS-1:0] chan_mask_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  // Register indexes on the configuration channel
  localparam cfg_idx_t REG_WAIT_TICKS     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RELEASE_TICKS  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_ACTIVE_LEVEL   = cfg_idx_t'(2);
  localparam cfg_idx_t REG_CHANNEL_ENABLE = cfg_idx_t'(3);

  // Pin level codes
  localparam logic LEVEL_LOW  = 1'b0;
  localparam logic LEVEL_HIGH = 1'b1;

  // Reset values
  localparam count_t     WAIT_TICKS_RST     = count_t'(10);
  localparam count_t     RELEASE_TICKS_RST  = count_t'(10);
  localparam logic       ACTIVE_LEVEL_RST   = LEVEL_LOW;
  localparam chan_mask_t CHANNEL_ENABLE_RST = '1;

  typedef struct packed {
    count_t     wait_ticks;
    count_t     release_ticks;
    logic       active_level;
    chan_mask_t channel_enable;
  } msp_cfg_t;

  typedef struct packed {
    chan_mask_t hit_mask;
    logic       mask_unknown;
    logic       detecting;
  } msp_result_t;

endpackage

/* hdl/msp_in_if.sv */
// Input channel of the presence qualifier: one sample of all sensor pins.
// Depends on msp_pkg.
interface msp_in_if;
  logic                 valid;
  logic                 ready;
  msp_pkg::chan_mask_t  pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

/* hdl/msp_out_if.sv */
// Result channel of the presence qualifier: hit mask and detection flags.
// Depends on msp_pkg.
interface msp_out_if;
  logic                 valid;
  logic                 ready;
  msp_pkg::chan_mask_t  hit_mask;
  logic                 mask_unknown;
  logic                 detecting;

  modport source (output valid, output hit_mask, output mask_unknown,
                  output detecting, input ready);
  modport sink   (input valid, input hit_mask, input mask_unknown,
                  input detecting, output ready);
endinterface

/* hdl/msp_cfg_if.sv */
// Configuration write channel of the presence qualifier.
// Depends on msp_pkg.
interface msp_cfg_if;
  logic                 valid;
  logic                 ready;
  msp_pkg::cfg_idx_t    index;
  msp_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/msp_cfg_regs.sv */
// Configuration register file of the presence qualifier.
// Depends on msp_pkg and msp_cfg_if.
module msp_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  msp_cfg_if.sink            cfg,
  output msp_pkg::msp_cfg_t  cfg_o
);
  import msp_pkg::*;

  msp_cfg_t cfg_r;
  msp_cfg_t cfg_nxt;

  // Always take a write transaction
  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_WAIT_TICKS:     cfg_nxt.wait_ticks     = count_t'(cfg.data);
        REG_RELEASE_TICKS:  cfg_nxt.release_ticks  = count_t'(cfg.data);
        REG_ACTIVE_LEVEL:   cfg_nxt.active_level   = cfg.data[0];
        REG_CHANNEL_ENABLE: cfg_nxt.channel_enable = cfg.data[NUM_CHANNELS-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_ticks     <= WAIT_TICKS_RST;
      cfg_r.release_ticks  <= RELEASE_TICKS_RST;
      cfg_r.active_level   <= ACTIVE_LEVEL_RST;
      cfg_r.channel_enable <= CHANNEL_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/msp_qual_core.sv */
// Qualifier core: hit detection, assert delay, release hold and phase state.
// Depends on msp_pkg.
module msp_qual_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  msp_pkg::chan_mask_t   pins,
  input  msp_pkg::msp_cfg_t     cfg,
  output msp_pkg::msp_result_t  res
);
  import msp_pkg::*;

  logic       det_r;
  logic       det_nxt;
  count_t     assert_cnt_r;
  count_t     assert_cnt_nxt;
  count_t     release_cnt_r;
  count_t     release_cnt_nxt;
  chan_mask_t hits;
  count_t     reload;

  // Channels at the active level and enabled
  assign hits = ((cfg.active_level == LEVEL_HIGH) ? pins : ~pins) & cfg.channel_enable;

  // Release hold reload, floored at zero
  assign reload = (cfg.release_ticks == '0) ? '0 : cfg.release_ticks - count_t'(1);

  // Next phase and counters for this tick
  always_comb begin
    det_nxt         = det_r;
    assert_cnt_nxt  = assert_cnt_r;
    release_cnt_nxt = release_cnt_r;
    if (hits != '0) begin
      if (!det_r) begin
        if (cfg.wait_ticks <= assert_cnt_r) begin
          det_nxt         = 1'b1;
          release_cnt_nxt = reload;
        end else if (assert_cnt_r != '1) begin
          assert_cnt_nxt = assert_cnt_r + count_t'(1);
        end
      end else begin
        release_cnt_nxt = reload;
      end
    end else begin
      // Quiet tick: count down the hold, release when it has run out
      if (release_cnt_r == '0) begin
        det_nxt = 1'b0;
      end else begin
        release_cnt_nxt = release_cnt_r - count_t'(1);
      end
      assert_cnt_nxt = '0;
    end
  end

  // Result of this tick
  always_comb begin
    res.hit_mask     = det_nxt ? hits : '0;
    res.mask_unknown = det_nxt && (hits == '0);
    res.detecting    = det_nxt;
  end

  // Advance the state once per processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r         <= 1'b0;
      assert_cnt_r  <= '0;
      release_cnt_r <= RELEASE_TICKS_RST;
    end else if (step) begin
      det_r         <= det_nxt;
      assert_cnt_r  <= assert_cnt_nxt;
      release_cnt_r <= release_cnt_nxt;
    end
  end

endmodule

/* hdl/multi_sensor_presence_qualifier.sv */
// Channel  Dir  Payload                                  Handshake
// in_ch    in   pin_levels[4:0]                          valid/ready
// out_ch   out  hit_mask[4:0], mask_unknown, detecting   valid/ready
// cfg_ch   in   index[7:0], data[15:0]                   valid/ready (ready always 1)
//
// One sample per clock while the result channel is not stalled: sample register,
// combinational qualifier logic, result register. The result is registered in
// the result register when the sample moves on from the sample register.
// Reset (rst_n low, synchronous) empties both registers and loads reset config.
// A stalled result holds in the result register; the sample register still
// accepts while the result register is free or being drained.
// Top level of the presence qualifier. Depends on msp_pkg, the three channel
// interfaces, msp_cfg_regs and msp_qual_core.
module multi_sensor_presence_qualifier (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_ch,
  msp_out_if.source out_ch,
  msp_cfg_if.sink   cfg_ch
);
  import msp_pkg::*;

  msp_cfg_t    cfg;
  logic        smp_valid_r;
  chan_mask_t  smp_pins_r;
  logic        out_valid_r;
  msp_result_t res_r;
  msp_result_t res_nxt;
  logic        advance;

  msp_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  msp_qual_core u_qual_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .pins  (smp_pins_r),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  // Move a sample into the result register when there is room
  assign advance     = smp_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !smp_valid_r || advance;

  // Sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      smp_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      smp_pins_r <= in_ch.pin_levels;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit_mask     = res_r.hit_mask;
  assign out_ch.mask_unknown = res_r.mask_unknown;
  assign out_ch.detecting    = res_r.detecting;

endmodule

/* hdl/msp_checker.sv */
// Port-level checks of the presence qualifier and the bind that attaches them.
// Depends on msp_pkg and multi_sensor_presence_qualifier_defines.svh.
`include "multi_sensor_presence_qualifier_defines.svh"

module msp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input msp_pkg::chan_mask_t  hit_mask,
  input logic                 mask_unknown,
  input logic                 detecting
);
  import msp_pkg::*;

  // A stalled result transaction keeps its payload
  `MSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hit_mask) && $stable(mask_unknown) && $stable(detecting), "result changed while stalled")

  // Unknown mask only while detecting with nothing hit
  `MSP_ASSERT_NOW(a_unknown_state, clk, rst_n, out_valid && mask_unknown, detecting && (hit_mask == '0), "mask_unknown outside detection")

  // Idle or released ticks report nothing
  `MSP_ASSERT_NOW(a_idle_quiet, clk, rst_n, out_valid && !detecting, (hit_mask == '0) && !mask_unknown, "report while not detecting")

  // While detecting, exactly one of mask and unknown flag is shown
  `MSP_ASSERT_NOW(a_det_report, clk, rst_n, out_valid && detecting, (hit_mask == '0) == mask_unknown, "mask and unknown flag disagree")

endmodule

bind multi_sensor_presence_qualifier msp_checker u_msp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hit_mask     (out_ch.hit_mask),
  .mask_unknown (out_ch.mask_unknown),
  .detecting    (out_ch.detecting)
);

/* tb/multi_sensor_presence_qualifier_tb.sv */
// Testbench for multi_sensor_presence_qualifier: drives sensor samples and
// register writes, predicts every result in a scoreboard class and checks it.
// Depends on msp_pkg, the three channel interfaces and the block itself.
module multi_sensor_presence_qualifier_tb;
  import msp_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int FLUSH_WAIT  = 4;
  localparam cfg_idx_t REG_UNUSED = '1;

  typedef enum logic [1:0] {
    PH_LOST, PH_START, PH_DETECTING, PH_RELEASED
  } qual_phase_e;

  // Scoreboard: own copy of the registers and qualifier state
  class presence_scoreboard;
    msp_cfg_t    regs;
    qual_phase_e phase;
    count_t      assert_cnt;
    count_t      release_cnt;
    msp_result_t expected_q[$];
    int unsigned errors;

    function new();
      regs.wait_ticks     = WAIT_TICKS_RST;
      regs.release_ticks  = RELEASE_TICKS_RST;
      regs.active_level   = ACTIVE_LEVEL_RST;
      regs.channel_enable = CHANNEL_ENABLE_RST;
      phase       = PH_LOST;
      assert_cnt  = '0;
      release_cnt = RELEASE_TICKS_RST;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_WAIT_TICKS:     regs.wait_ticks     = count_t'(data);
        REG_RELEASE_TICKS:  regs.release_ticks  = count_t'(data);
        REG_ACTIVE_LEVEL:   regs.active_level   = data[0];
        REG_CHANNEL_ENABLE: regs.channel_enable = data[NUM_CHANNELS-1:0];
        default: ;
      endcase
    endfunction

    // Hold reload after a hit; a zero hold saturates at zero
    function count_t hold_reload();
      return (regs.release_ticks == '0) ? count_t'(0) : regs.release_ticks - count_t'(1);
    endfunction

    // Advance the qualifier by one tick and queue its result
    function void note_sample(chan_mask_t pins);
      chan_mask_t  lvl;
      chan_mask_t  hits;
      msp_result_t res;
      lvl  = (regs.active_level == LEVEL_HIGH) ? pins : ~pins;
      hits = lvl & regs.channel_enable;
      if (hits != '0) begin
        if (phase == PH_LOST) begin
          if (regs.wait_ticks <= assert_cnt) begin
            phase       = PH_START;
            release_cnt = hold_reload();
          end else if (assert_cnt != '1) begin
            assert_cnt++;
          end
        end else if (phase == PH_START || phase == PH_DETECTING) begin
          release_cnt = hold_reload();
        end
      end else begin
        if (release_cnt == '0) begin
          if (phase == PH_START || phase == PH_DETECTING) phase = PH_RELEASED;
        end else begin
          release_cnt--;
        end
        assert_cnt = '0;
      end
      if (phase == PH_START || phase == PH_DETECTING) begin
        res.hit_mask     = hits;
        res.mask_unknown = (hits == '0);
        phase            = PH_DETECTING;
      end else begin
        res.hit_mask     = '0;
        res.mask_unknown = 1'b0;
        phase            = PH_LOST;
      end
      res.detecting = (phase == PH_DETECTING);
      expected_q.push_back(res);
    endfunction

    function void check_result(chan_mask_t mask, logic unknown, logic det);
      msp_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no pending expectation: hit_mask %0h", mask);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (mask !== exp_res.hit_mask) begin
        $error("hit_mask: expected %0h, got %0h", exp_res.hit_mask, mask);
        errors++;
      end
      if (unknown !== exp_res.mask_unknown) begin
        $error("mask_unknown: expected %0b, got %0b", exp_res.mask_unknown, unknown);
        errors++;
      end
      if (det !== exp_res.detecting) begin
        $error("detecting: expected %0b, got %0b", exp_res.detecting, det);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;

  presence_scoreboard sb = new();

  msp_in_if  in_ch();
  msp_out_if out_ch();
  msp_cfg_if cfg_ch();

  multi_sensor_presence_qualifier i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Track accepted transactions on every channel
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.pin_levels);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.hit_mask, out_ch.mask_unknown, out_ch.detecting);
    end
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Stall the result channel at random
  initial begin : out_stall
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Drop the run if nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Present one sample after a random gap and hold it until accepted
  task automatic send_sample(chan_mask_t pins);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pin_levels <= pins;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
  endtask

  // One register write; valid stays high for a following write
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all four registers with random junk in the unused data bits
  task automatic write_settings(count_t w, count_t r, logic lvl, chan_mask_t en);
    cfg_data_t d;
    write_reg(REG_WAIT_TICKS, cfg_data_t'(w));
    write_reg(REG_RELEASE_TICKS, cfg_data_t'(r));
    d = cfg_data_t'($urandom);
    d[0] = lvl;
    write_reg(REG_ACTIVE_LEVEL, d);
    d = cfg_data_t'($urandom);
    d[NUM_CHANNELS-1:0] = en;
    write_reg(REG_CHANNEL_ENABLE, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // Build pins that give at least one hit, or none at all
  function automatic chan_mask_t make_pins(bit want_hit);
    chan_mask_t p;
    chan_mask_t en;
    int i;
    p  = chan_mask_t'($urandom);
    en = sb.regs.channel_enable;
    if (want_hit && en != '0) begin
      do i = $urandom_range(0, NUM_CHANNELS-1); while (!en[i]);
      p[i] = sb.regs.active_level;
    end else if (!want_hit) begin
      if (sb.regs.active_level == LEVEL_HIGH) p = p & ~en;
      else p = p | en;
    end
    return p;
  endfunction

  // Run length around the assert delay or the release hold
  function automatic int run_length(bit hit_run);
    int lim;
    lim = hit_run ? int'(sb.regs.wait_ticks) : int'(sb.regs.release_ticks);
    if (lim <= 24) return $urandom_range(1, lim + 6);
    return $urandom_range(1, 24);
  endfunction

  // Alternate runs of hits and quiet ticks, with some noise mixed in
  task automatic run_random(int n_items, bit pause_mid);
    int sent;
    int len;
    bit hit_run;
    chan_mask_t p;
    sent    = 0;
    hit_run = $urandom_range(0, 1);
    while (sent < n_items) begin
      len = run_length(hit_run);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 99) < 12) p = chan_mask_t'($urandom);
        else p = make_pins(hit_run);
        send_sample(p);
        sent++;
        if (pause_mid && sent == n_items / 2) drain_results();
      end
      hit_run = !hit_run;
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    no_idle          = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.pin_levels <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: qualify, start, unknown mask, release, idle quiet
    send_sample(5'h1F);
    repeat (11) send_sample(5'h00);
    send_sample(5'h15);
    send_sample(5'h1E);
    repeat (11) send_sample(5'h1F);
    drain_results();

    // Out-of-range index is dropped, wide data is truncated
    write_reg(REG_UNUSED, 16'h0000);
    write_reg(REG_ACTIVE_LEVEL, 16'hABCD);
    write_reg(REG_CHANNEL_ENABLE, 16'hFFF3);
    cfg_ch.valid <= 1'b0;
    run_random(100, 1'b1);

    // Extreme settings first, then random small ones
    for (int ph = 0; ph < 11; ph++) begin
      no_idle = (ph % 4 == 2);
      case (ph)
        0: write_settings(16'd0, 16'd0, LEVEL_HIGH, 5'h1F);
        1: write_settings(16'd1, 16'd1, LEVEL_LOW, 5'h1F);
        2: write_settings(16'hFFFF, 16'hFFFF, LEVEL_HIGH, 5'h1F);
        3: write_settings(16'd3, 16'd0, LEVEL_LOW, 5'h15);
        4: write_settings(16'd0, 16'hFFFF, LEVEL_HIGH, 5'h1F);
        5: write_settings(16'd2, 16'd2, LEVEL_LOW, 5'h00);
        6: write_settings(16'hFFFF, 16'd0, LEVEL_LOW, 5'h01);
        default: write_settings(count_t'($urandom_range(0, 12)),
                                count_t'($urandom_range(0, 12)),
                                logic'($urandom_range(0, 1)),
                                chan_mask_t'($urandom));
      endcase
      run_random(100, 1'(ph % 2));
    end
    no_idle = 1'b0;

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
